// ===== rtl/lru_page_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// lru_page_replacement_defines.svh
// Assertion macros shared by the LRU page replacement checkers.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Property checked on every edge, reset included.
`define LRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked outside reset.
`define LRU_ASSERT_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/lru_pr_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru_pr_pkg;

  // Default sizing
  localparam int FRAMES_DEF     = 16;
  localparam int PAGE_WIDTH_DEF = 16;

  // Fixed port widths
  localparam int PAGE_NUM_W  = 16;
  localparam int FRAME_IDX_W = 4;
  localparam int CFG_W       = 5;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

endpackage

// ===== rtl/lru_pr_victim.sv =====
// ----------------------------------------------------------------------------
// lru_pr_victim
// Picks the oldest active frame; ties go to the lowest index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_pr_victim #(
  parameter int FRAMES = 16,
  parameter int RANK_W = 4
) (
  input  logic [FRAMES-1:0][RANK_W-1:0] rank,
  input  logic [FRAMES-1:0]             active,
  output logic [FRAMES-1:0]             victim_oh
);

  // Pairwise compare: a frame wins if it beats every lower active frame
  // strictly and every higher one or equal.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      victim_oh[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (j < i) begin
          if (active[j] && !(rank[i] > rank[j])) victim_oh[i] = 1'b0;
        end else if (j > i) begin
          if (active[j] && !(rank[i] >= rank[j])) victim_oh[i] = 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU frame table: one page request per word.
//   Requests pass the input register, then the result register.
//   Throughput: 1 word per cycle; busy is never raised, the table update
//   (tag compare, victim pick, rank update) is combinational.
//   Results cannot be stalled: result_valid is a one-cycle strobe.
//   Reset (rst, sync, active high): table empty, ranks zero,
//   frames_in_use = FRAMES. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int FRAMES     = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_WIDTH = lru_pr_pkg::PAGE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [lru_pr_pkg::PAGE_NUM_W-1:0] page_number,
  // result
  output logic                              result_valid,
  output logic                              page_fault,
  output logic [lru_pr_pkg::FRAME_IDX_W-1:0] frame_index,
  output logic                              evict_valid,
  output logic [lru_pr_pkg::PAGE_NUM_W-1:0] evicted_page,
  // APB config
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lru_pr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lru_pr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lru_pr_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);

  import lru_pr_pkg::*;

  localparam int RANK_W = $clog2(FRAMES);
  localparam int FIDX_W = $clog2(FRAMES);
  localparam int CNT_W  = $clog2(FRAMES + 1);
  // frames_in_use must be able to hold FRAMES at reset
  localparam int FIU_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  logic [FIU_W-1:0] frames_in_use;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_W'(FRAMES);
    end else if (cfg_wr && paddr[2] == REG_FRAMES_IN_USE) begin
      frames_in_use <= FIU_W'(pwdata[CFG_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IN_USE) prdata = APB_DATA_W'(frames_in_use);
  end

  // Active frame count: 0 acts as 1, anything above FRAMES as FRAMES
  logic [CNT_W-1:0]  n_active;
  logic [FRAMES-1:0] active;

  always_comb begin
    if (frames_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(frames_in_use);
    end
    for (int i = 0; i < FRAMES; i++) active[i] = (32'(i) < 32'(n_active));
  end

  // --------------------------------------------------------------------------
  // Input register: no backpressure, a word every cycle
  // --------------------------------------------------------------------------
  logic                  in_valid;
  logic [PAGE_WIDTH-1:0] in_page;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else     in_valid <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_page <= PAGE_WIDTH'(page_number);
  end

  // --------------------------------------------------------------------------
  // Frame table
  // --------------------------------------------------------------------------
  logic [FRAMES-1:0][PAGE_WIDTH-1:0] frame_pages;   // no reset, read only when valid
  logic [FRAMES-1:0]                 frame_valid;
  logic [FRAMES-1:0][RANK_W-1:0]     recency_rank;  // 0 = most recent
  logic [CNT_W-1:0]                  filled_count;

  // Tag compare, lowest matching active frame wins
  logic [FRAMES-1:0] match, hit_oh;
  logic              hit;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = frame_valid[i] && active[i] && (frame_pages[i] == in_page);
    end
    hit_oh = match & (~match + FRAMES'(1));
    hit    = |match;
  end

  // Fill goes to the next free slot while the active range has room
  logic              fill;
  logic [FRAMES-1:0] fill_oh;

  assign fill = !hit && (filled_count < n_active);

  always_comb begin
    for (int i = 0; i < FRAMES; i++) fill_oh[i] = (32'(filled_count) == i);
  end

  // Victim: oldest active frame
  logic [FRAMES-1:0] victim_oh;

  lru_pr_victim #(
    .FRAMES (FRAMES),
    .RANK_W (RANK_W)
  ) u_victim (
    .rank      (recency_rank),
    .active    (active),
    .victim_oh (victim_oh)
  );

  // Selected frame and what it held
  logic [FRAMES-1:0]     sel_oh;
  logic [FIDX_W-1:0]     sel_idx;
  logic [RANK_W-1:0]     old_rank;
  logic [PAGE_WIDTH-1:0] old_page;
  logic                  evict;

  assign evict = !hit && !fill;

  always_comb begin
    if (hit)       sel_oh = hit_oh;
    else if (fill) sel_oh = fill_oh;
    else           sel_oh = victim_oh;
    sel_idx  = '0;
    old_rank = '0;
    old_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel_oh[i]) begin
        sel_idx  = sel_idx | FIDX_W'(i);
        old_rank = old_rank | recency_rank[i];
      end
      if (victim_oh[i]) old_page = old_page | frame_pages[i];
    end
  end

  // Rank update: the touched frame goes to 0, valid frames younger than
  // its old rank age by one (a fill ages every valid frame), saturating.
  logic [FRAMES-1:0][RANK_W-1:0] rank_next;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (sel_oh[i]) begin
        rank_next[i] = '0;
      end else if (frame_valid[i] && recency_rank[i] < RANK_MAX &&
                   (fill || recency_rank[i] < old_rank)) begin
        rank_next[i] = recency_rank[i] + RANK_W'(1);
      end else begin
        rank_next[i] = recency_rank[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid  <= '0;
      recency_rank <= '0;
      filled_count <= '0;
    end else if (in_valid) begin
      recency_rank <= rank_next;
      if (!hit) frame_valid <= frame_valid | sel_oh;
      if (fill) filled_count <= filled_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAMES; i++) begin
      if (in_valid && !hit && sel_oh[i]) frame_pages[i] <= in_page;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: one-cycle strobe
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      page_fault   <= !hit;
      frame_index  <= FRAME_IDX_W'(sel_idx);
      evict_valid  <= evict;
      evicted_page <= evict ? PAGE_NUM_W'(old_page) : '0;
    end
  end

endmodule

// ===== rtl/lru_pr_checker.sv =====
// ----------------------------------------------------------------------------
// lru_pr_checker
// Port-level checks on the LRU page replacement block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_page_replacement_defines.svh"

module lru_pr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              result_valid,
  input logic                              page_fault,
  input logic                              evict_valid,
  input logic [lru_pr_pkg::PAGE_NUM_W-1:0] evicted_page
);

  `LRU_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")
  `LRU_ASSERT_RUN(a_result_follows, clk, rst, start && !busy |-> ##2 result_valid, "word lost")
  `LRU_ASSERT_RUN(a_no_phantom, clk, rst, result_valid |-> $past(start && !busy, 2), "extra result")
  `LRU_ASSERT_RUN(a_evict_is_fault, clk, rst, result_valid && evict_valid |-> page_fault, "evict without fault")
  `LRU_ASSERT_RUN(a_evict_zero, clk, rst, result_valid && !evict_valid |-> evicted_page == '0, "stale evicted page")

endmodule

bind lru_page_replacement lru_pr_checker u_lru_pr_checker (.*);

// ===== tb/sv/lru_page_replacement_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Self-checking bench for the fully associative LRU frame table. A short
// table of directed page requests and register writes covers the extremes and
// corner cases. Random phases follow, each with a frame count set anew. A
// behavioral copy of the table predicts every result word, and the words are
// compared field by field as they strobe out.
// ----------------------------------------------------------------------------

module lru_page_replacement_test;
  import lru_pr_pkg::*;

  localparam int FRAMES           = FRAMES_DEF;
  localparam int NUM_PHASES       = 10;
  localparam int WORDS_PER_PHASE  = 153;
  localparam int POOL_DEPTH       = 24;
  localparam int CYCLE_LIMIT      = 500_000;
  localparam int MAX_REPORTS      = 10;
  localparam int SETTLE_CYCLES    = 8;

  // paddr[2] selects the register; the odd slot is not decoded
  localparam logic REG_SPARE = ~REG_FRAMES_IN_USE;

  // One result word as it appears on the result ports
  typedef struct packed {
    logic                   page_fault;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evict_valid;
    logic [PAGE_NUM_W-1:0]  evicted_page;
  } result_word_t;

  typedef enum logic {ROW_PAGE, ROW_REG} row_kind_t;

  // Directed step: a page request, or a register write between phases.
  // Where typed is set, want is pushed instead of the predicted word.
  typedef struct packed {
    row_kind_t       kind;
    logic            reg_idx;
    logic [31:0]     data;
    logic            typed;
    result_word_t    want;
  } plan_row_t;

  localparam result_word_t NONE = '0;
  localparam int PLAN_ROWS = 21;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // empty table, 16 frames: fill frames 0 and 1, then hit both
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000}},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_FFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000}},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000}},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_FFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000}},
    // shrink to 2 frames: table is full, frame 0 is oldest, page zero evicted
    '{ROW_REG,  REG_FRAMES_IN_USE, 32'h0000_0002, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_1234, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h0000}},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_1234, 1'b0, NONE},
    // zero acts as one frame; FFFF lives only in inactive frame 1 -> miss
    '{ROW_REG,  REG_FRAMES_IN_USE, 32'h0000_0000, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_FFFF, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h1234}},
    // upper data bits dropped -> 16; FFFF now in frames 0 and 1, lowest wins
    '{ROW_REG,  REG_FRAMES_IN_USE, 32'hFFFF_FFF0, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_FFFF, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000}},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_AAAA, 1'b1, '{1'b1, 4'd2, 1'b0, 16'h0000}},
    // above range clamps to 16; fill resumes where it left off
    '{ROW_REG,  REG_FRAMES_IN_USE, 32'h0000_001F, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_5555, 1'b0, NONE},
    // write to the spare slot must not touch the frame count
    '{ROW_REG,  REG_SPARE,         32'h0000_0001, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_0001, 1'b1, '{1'b1, 4'd4, 1'b0, 16'h0000}},
    // one frame: hit on frame 0, then replace it
    '{ROW_REG,  REG_FRAMES_IN_USE, 32'h0000_0001, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_FFFF, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000}},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_8000, 1'b1, '{1'b1, 4'd0, 1'b1, 16'hFFFF}},
    // back to 16: FFFF still held by frame 1
    '{ROW_REG,  REG_FRAMES_IN_USE, 32'h0000_0010, 1'b0, NONE},
    '{ROW_PAGE, REG_FRAMES_IN_USE, 32'h0000_FFFF, 1'b0, NONE}
  };

  // DUT ports, all driven from time zero
  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [PAGE_NUM_W-1:0] page_number  = '0;
  logic                  result_valid;
  logic                  page_fault;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic                  evict_valid;
  logic [PAGE_NUM_W-1:0] evicted_page;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_page_replacement dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page_number  (page_number),
    .result_valid (result_valid),
    .page_fault   (page_fault),
    .frame_index  (frame_index),
    .evict_valid  (evict_valid),
    .evicted_page (evicted_page),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Behavioral frame table: the predictor's private copy of the DUT state
  logic [PAGE_NUM_W-1:0] resident_page [FRAMES];
  logic                  resident      [FRAMES];
  logic [3:0]            age_rank      [FRAMES];
  int                    frames_filled;
  logic [CFG_W-1:0]      frames_cfg;

  // Words predicted for accepted requests, oldest first
  result_word_t pending_lookups [$];

  int mismatch_count = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the DUT hangs or drops words
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Frame f becomes newest; valid frames younger than its old rank age by one.
  // Inactive frames keep aging too, which is why all FRAMES are walked.
  function automatic void promote_frame(input int f, input int old_rank);
    int i;
    for (i = 0; i < FRAMES; i++)
      if (i != f && resident[i] && age_rank[i] < old_rank && age_rank[i] < FRAMES - 1)
        age_rank[i] = age_rank[i] + 4'd1;
    age_rank[f] = '0;
  endfunction

  // Predict the word for one request and update the table
  function automatic result_word_t lookup_and_replace(input logic [PAGE_NUM_W-1:0] page);
    result_word_t r;
    int active, i, f;
    bit found;
    r      = '0;
    found  = 1'b0;
    f      = 0;
    // register is clamped to 1..FRAMES, not stored clamped
    if (frames_cfg == 0)           active = 1;
    else if (frames_cfg > FRAMES)  active = FRAMES;
    else                           active = frames_cfg;

    // hit search: lowest active match wins
    for (i = 0; i < active; i++)
      if (!found && resident[i] && resident_page[i] == page) begin
        found = 1'b1;
        f     = i;
      end

    if (found) begin
      promote_frame(f, age_rank[f]);
      r.frame_index = f[FRAME_IDX_W-1:0];
    end else if (frames_filled < active) begin
      // free frame: counts as older than anything resident
      f = frames_filled;
      frames_filled++;
      promote_frame(f, FRAMES);
      resident_page[f] = page;
      resident[f]      = 1'b1;
      r.page_fault     = 1'b1;
      r.frame_index    = f[FRAME_IDX_W-1:0];
    end else begin
      // full: oldest active frame, ties to the lowest index
      for (i = 1; i < active; i++)
        if (age_rank[i] > age_rank[f])
          f = i;
      r.page_fault     = 1'b1;
      r.frame_index    = f[FRAME_IDX_W-1:0];
      r.evict_valid    = 1'b1;
      r.evicted_page   = resident_page[f];
      promote_frame(f, age_rank[f]);
      resident_page[f] = page;
      resident[f]      = 1'b1;
    end
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drop start for the requested gap; scribble on page_number so idle data is ignored
  task automatic idle_for(input int n);
    if (n > 0) begin
      start       <= 1'b0;
      page_number <= PAGE_NUM_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off requests until every predicted word has come back.
  // With nothing pending, start is already low.
  task automatic idle_until_drained();
    if (pending_lookups.size() != 0) begin
      start <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clk);
    end
  endtask

  // Present one request, wait for the accepting edge, then queue its word.
  // start is left high so a following request can go back to back.
  task automatic send_request(input logic [PAGE_NUM_W-1:0] page, input logic typed,
                              input result_word_t want);
    result_word_t predicted;
    start       <= 1'b1;
    page_number <= page;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = lookup_and_replace(page);
    pending_lookups.push_back(typed ? want : predicted);
  endtask

  // Setup cycle, then access cycle until pready
  task automatic apb_cycle(input logic wr, input logic idx, input logic [31:0] data,
                           output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the frame count, mirror it, and read it back after idling
  task automatic set_frames_in_use(input logic [31:0] data);
    logic [31:0] rd;
    apb_cycle(1'b1, REG_FRAMES_IN_USE, data, rd);
    frames_cfg = data[CFG_W-1:0];
    @(posedge clk);
    apb_cycle(1'b0, REG_FRAMES_IN_USE, '0, rd);
    if (rd !== {{(APB_DATA_W-CFG_W){1'b0}}, frames_cfg})
      note_mismatch($sformatf("frames_in_use readback exp %0d got %h", frames_cfg, rd));
  endtask

  // Result check: every strobe pops the oldest prediction
  always @(posedge clk) begin : word_check
    result_word_t got;
    result_word_t want;
    if (!rst && result_valid === 1'b1) begin
      got = '{page_fault, frame_index, evict_valid, evicted_page};
      if (pending_lookups.size() == 0) begin
        note_mismatch($sformatf("unexpected word fault=%b frame=%0d evict=%b page=%h",
                                got.page_fault, got.frame_index, got.evict_valid,
                                got.evicted_page));
      end else begin
        want = pending_lookups.pop_front();
        if (got.page_fault !== want.page_fault || got.frame_index !== want.frame_index ||
            got.evict_valid !== want.evict_valid || got.evicted_page !== want.evicted_page)
          note_mismatch($sformatf(
            "exp fault=%b frame=%0d evict=%b page=%h got fault=%b frame=%0d evict=%b page=%h",
            want.page_fault, want.frame_index, want.evict_valid, want.evicted_page,
            got.page_fault, got.frame_index, got.evict_valid, got.evicted_page));
      end
    end
  end

  initial begin : stimulus
    logic [PAGE_NUM_W-1:0] pool [POOL_DEPTH];
    logic [31:0]           rd;
    logic [31:0]           cfg_data;
    int                    phase_frames [NUM_PHASES];
    int                    k, p, n, active, span;
    bit                    no_gaps;
    logic [PAGE_NUM_W-1:0] page;

    // mirror of the reset state
    for (k = 0; k < FRAMES; k++) begin
      resident_page[k] = '0;
      resident[k]      = 1'b0;
      age_rank[k]      = '0;
    end
    frames_filled = 0;
    frames_cfg    = CFG_W'(FRAMES);

    // frame counts per random phase: both ends, out of range, and one random
    phase_frames = '{16, 1, 7, 31, 0, 2, 12, 17, 16, 4};
    phase_frames[8] = $urandom_range(0, 31);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (k = 0; k < PLAN_ROWS; k++) begin
      if (PLAN[k].kind == ROW_REG) begin
        idle_until_drained();
        if (PLAN[k].reg_idx == REG_FRAMES_IN_USE)
          set_frames_in_use(PLAN[k].data);
        else
          apb_cycle(1'b1, PLAN[k].reg_idx, PLAN[k].data, rd);
      end else begin
        send_request(PLAN[k].data[PAGE_NUM_W-1:0], PLAN[k].typed, PLAN[k].want);
        idle_for(pick_gap());
      end
    end

    // random phases: a fresh page pool per phase, sized a little past the
    // active frame count so hits, fills and evictions all show up
    for (p = 0; p < NUM_PHASES; p++) begin
      idle_until_drained();
      cfg_data = 32'(phase_frames[p]);
      if (p % 2 == 1)
        cfg_data = cfg_data | ($urandom & 32'hFFFF_FFE0);
      set_frames_in_use(cfg_data);

      active = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
      span   = (active + 3 < POOL_DEPTH) ? active + 3 : POOL_DEPTH - 1;
      for (k = 0; k < POOL_DEPTH; k++)
        pool[k] = PAGE_NUM_W'($urandom);
      no_gaps = ($urandom_range(0, 2) == 0);

      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 8)
          page = PAGE_NUM_W'($urandom);
        else
          page = pool[$urandom_range(0, span)];
        send_request(page, 1'b0, NONE);
        if (!no_gaps)
          idle_for(pick_gap());
        // occasional full drain with the pipe otherwise busy
        if ($urandom_range(0, 199) == 0)
          idle_until_drained();
      end
    end

    idle_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
